FILE: hdl/sha256_pkg.sv
// SHA-256 package: controller state type, command/status structs, round
// constants, initial hash values and the round and schedule functions.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } ctl_state_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Controller to datapath.
  typedef struct packed {
    logic       absorb;     // write in byte at fill count, count bits
    logic       pad_write;  // write one padding byte at pad pointer
    logic       pad_start;  // load pad pointer at fill count, arm 0x80 write
    logic       round_init; // load working vars from hash state
    logic       round_step; // run one round
    logic       fold;       // feed-forward add
    logic       restart;    // reload initial hash, clear counts
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       block_full; // absorb just filled the buffer
    logic       pad_done;   // pad pointer wrote last byte of this block
    logic       pad_extra;  // padding needs a further block
    logic       last_round; // round counter at 63
  } dp_stat_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int amt);
    rotr = (v >> amt) | (v << (32 - amt));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: hdl/sha256_ctl.sv
// SHA-256 controller: sequences absorb, padding, rounds, fold and digest emit.
// Depends on sha256_pkg.
module sha256_ctl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_action,
  input  dp_stat_t   stat,
  input  logic       out_fire,
  output logic       in_ready,
  output logic       emit_valid,
  output logic [2:0] emit_index,
  output dp_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic       final_r, final_nxt;   // block in flight is the last of a message
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_FINISH) begin
            state_nxt = ST_PAD;
          end else if (stat.block_full) begin
            state_nxt = ST_ROUND;
            final_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        if (stat.pad_done) begin
          state_nxt = ST_ROUND;
          final_nxt = !stat.pad_extra;
        end
      end
      ST_ROUND: begin
        if (stat.last_round) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end else if (stat.pad_extra) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    emit_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.absorb     = in_fire && (in_action == ACT_ABSORB);
        cmd.pad_start  = in_fire && (in_action == ACT_FINISH);
        cmd.round_init = in_fire && (in_action == ACT_ABSORB) && stat.block_full;
      end
      ST_PAD: begin
        cmd.pad_write  = 1'b1;
        cmd.round_init = stat.pad_done;
      end
      ST_ROUND: cmd.round_step = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_EMIT: begin
        emit_valid  = 1'b1;
        cmd.restart = out_fire && (idx_r == 3'd7);
      end
      default: ;
    endcase
  end

  assign emit_index = idx_r;

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid |-> !in_ready) else $error("emit while accepting");
  a_restart_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> state_r == ST_IDLE) else $error("restart not at end");
  a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD |-> $past(state_r) == ST_ROUND) else $error("fold order");

endmodule

FILE: hdl/sha256_dp.sv
// SHA-256 datapath: block buffer memory, 16-word schedule window, round unit,
// chaining state and bit counter. Depends on sha256_pkg.
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  input  logic [2:0]  emit_index,
  output dp_stat_t    stat,
  output logic [31:0] digest_word
);

  // Buffer as 16 words of 4 bytes: byte writes, whole-row load at round start.
  logic [31:0] buf_mem [16];
  logic [31:0] hash_r [8];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]  fill_r, round_r, pad_r;
  logic [63:0] bits_r;
  logic        extra_r;   // padding spills into a further block
  logic        lead_r;    // next padding write is the 0x80 marker

  // Byte write port.
  logic       wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r;
    wr_data = in_byte;
    if (cmd.absorb) begin
      wr_en = 1'b1;
    end else if (cmd.pad_write) begin
      wr_en   = 1'b1;
      wr_addr = pad_r;
      if (lead_r) begin
        wr_data = PAD_BYTE;
      end else if (pad_r >= LEN_POS && !extra_r) begin
        wr_data = bits_r[6'(63 - 8 * int'(pad_r[2:0])) -: 8];
      end else begin
        wr_data = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr[5:2]][5'(31 - 8 * int'(wr_addr[1:0])) -: 8] <= wr_data;
  end

  // Padding pointer: walks from the 0x80 marker, or byte 0, to the block end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r   <= '0;
      extra_r <= 1'b0;
      lead_r  <= 1'b0;
    end else if (cmd.pad_start) begin
      pad_r   <= fill_r;
      extra_r <= (fill_r >= 6'd56);
      lead_r  <= 1'b1;
    end else if (cmd.pad_write) begin
      pad_r  <= pad_r + 6'd1;
      lead_r <= 1'b0;
    end else if (cmd.fold && extra_r) begin
      pad_r   <= '0;
      extra_r <= 1'b0;
    end
  end

  // Every padding sweep ends on byte 63, the block boundary.
  logic pad_finish_now;
  assign pad_finish_now = (pad_r == 6'd63);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bits_r <= '0;
    end else if (cmd.restart) begin
      fill_r <= '0;
      bits_r <= '0;
    end else if (cmd.absorb) begin
      fill_r <= fill_r + 6'd1;
      bits_r <= bits_r + 64'd8;
    end
  end

  // Round unit.
  logic [31:0] w_new, t1, t2, w_cur;
  assign w_cur = w_r[0];
  assign w_new = w_r[0] + sig0(w_r[1]) + w_r[9] + sig1(w_r[14]);
  assign t1 = h_r + big1(e_r) + ((e_r & f_r) ^ (~e_r & g_r)) + ROUND_K[round_r] + w_cur;
  assign t2 = big0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  always_ff @(posedge clk) begin
    if (cmd.round_init) begin
      a_r <= hash_r[0]; b_r <= hash_r[1]; c_r <= hash_r[2]; d_r <= hash_r[3];
      e_r <= hash_r[4]; f_r <= hash_r[5]; g_r <= hash_r[6]; h_r <= hash_r[7];
    end else if (cmd.round_step) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
    end
    // Byte 63 is written in the load cycle itself: merge it from the write port.
    if (cmd.round_init) begin
      for (int i = 0; i < 15; i++) w_r[i] <= buf_mem[i];
      w_r[15] <= {buf_mem[15][31:8], wr_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= '0;
    end else if (cmd.round_step) begin
      round_r <= round_r + 6'd1;
    end else begin
      round_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= H_INIT[i];
    end else if (cmd.fold) begin
      hash_r[0] <= hash_r[0] + a_r; hash_r[1] <= hash_r[1] + b_r;
      hash_r[2] <= hash_r[2] + c_r; hash_r[3] <= hash_r[3] + d_r;
      hash_r[4] <= hash_r[4] + e_r; hash_r[5] <= hash_r[5] + f_r;
      hash_r[6] <= hash_r[6] + g_r; hash_r[7] <= hash_r[7] + h_r;
    end
  end

  assign digest_word     = hash_r[emit_index];
  assign stat.block_full = cmd.absorb && (fill_r == 6'd63);
  assign stat.pad_done   = cmd.pad_write && pad_finish_now;
  assign stat.pad_extra  = extra_r;
  assign stat.last_round = (round_r == 6'd63);

  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> fill_r == '0 && bits_r == '0) else $error("restart failed");
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> $past(round_r) == 6'd63) else $error("fold before 64 rounds");
  a_bits_track: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.absorb |=> bits_r[8:3] == fill_r) else $error("bit count drift");

endmodule

FILE: hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: joins the controller and the datapath.
// Depends on sha256_pkg, sha256_ctl, sha256_dp.
//
//  channel | dir | ports                  | contents
//  --------+-----+------------------------+---------------------------------
//  in      | in  | tvalid/tready/tdata/tuser | tdata=data_byte, tuser=action
//  out     | out | tvalid/tready/tdata/tuser/tlast | tdata=digest_word,
//          |     |                        | tuser=word_index, tlast=last_word
//
// An absorb writes one byte and, when it fills a block, starts compression
// (64 rounds on a single round unit, then a fold). A finish starts a padding
// sweep of 64 - fill byte writes and a compression; when the length needs a
// further block, another 64-write sweep and compression follow; then eight
// output transfers. rst_n is synchronous, active low, and restores the
// initial hash. A stalled out_tready holds the current digest word.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] emit_index;
  logic       in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  sha256_ctl u_ctl (
    .clk, .rst_n, .in_fire, .in_action(in_tuser), .stat, .out_fire,
    .in_ready(in_tready), .emit_valid(out_tvalid), .emit_index, .cmd
  );

  sha256_dp u_dp (
    .clk, .rst_n, .in_byte(in_tdata), .cmd, .emit_index, .stat,
    .digest_word(out_tdata)
  );

  assign out_tuser = emit_index;
  assign out_tlast = (emit_index == 3'd7);

endmodule
